// ----- src/spp_pkg.sv -----
// Shared types and constants of the sprite screen projection core.
// No dependencies; every other file of the block except spp_div refers to this package by scoped names.
package spp_pkg;

    // Field widths
    localparam int POS_W    = 24;
    localparam int VEC_W    = 16;
    localparam int DIM_W    = 13;
    localparam int DEPTH_W  = 25;
    localparam int CENTRE_W = 14;
    localparam int SIZE_W   = 13;
    localparam int COORD_W  = 12;
    localparam int TEX_W    = 8;
    localparam int TW_W     = 9;

    // Transform widths
    localparam int DELTA_W   = 25;
    localparam int PROD_W    = 41;
    localparam int NUM_W     = 42;
    localparam int NUM_MAG_W = 41;
    localparam int DET_W     = 33;
    localparam int DET_MAG_W = 32;
    localparam int VEC_SHIFT = 14;
    localparam int TX_W      = 42;
    localparam int TQ_W      = 41;
    localparam int SUM_W     = 43;
    localparam int SUM_MAG_W = 41;

    // Register indexes
    localparam logic [2:0] CFG_CAMERA_X     = 3'd0;
    localparam logic [2:0] CFG_CAMERA_Y     = 3'd1;
    localparam logic [2:0] CFG_VIEW_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_VIEW_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_CAM_PLANE_X  = 3'd4;
    localparam logic [2:0] CFG_CAM_PLANE_Y  = 3'd5;
    localparam logic [2:0] CFG_SCREEN_WIDTH = 3'd6;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd7;

    // Saturation limits
    localparam logic [TQ_W-1:0]     TX_LIMIT      = 41'h100_0000_0000;
    localparam logic [TQ_W-1:0]     DEPTH_POS_MAG = 41'h000_00FF_FFFF;
    localparam logic [TQ_W-1:0]     DEPTH_NEG_MAG = 41'h000_0100_0000;
    localparam logic [CENTRE_W-1:0] CENTRE_POS_MAG = 14'd8191;
    localparam logic [CENTRE_W-1:0] CENTRE_NEG_MAG = 14'd8192;
    localparam logic [SIZE_W-1:0]   SIZE_MAX      = 13'd8191;
    localparam logic [DIM_W-1:0]    DIM_MAX       = 13'd4096;

    typedef struct packed {
        logic [POS_W-1:0]        cam_x;
        logic [POS_W-1:0]        cam_y;
        logic signed [VEC_W-1:0] dir_x;
        logic signed [VEC_W-1:0] dir_y;
        logic signed [VEC_W-1:0] plane_x;
        logic signed [VEC_W-1:0] plane_y;
        logic [DIM_W-1:0]        width;
        logic [DIM_W-1:0]        height;
    } spp_cfg_t;

    typedef struct packed {
        logic signed [TX_W-1:0]    tx;
        logic signed [DEPTH_W-1:0] ty;
        logic                      kind;
    } spp_xf_t;

    typedef struct packed {
        logic                       behind;
        logic signed [DEPTH_W-1:0]  depth;
        logic signed [CENTRE_W-1:0] centre;
        logic [SIZE_W-1:0]          size;
        logic                       kind;
    } spp_proj_t;

    typedef struct packed {
        logic                       behind;
        logic signed [DEPTH_W-1:0]  depth;
        logic signed [CENTRE_W-1:0] centre;
        logic [SIZE_W-1:0]          size;
        logic [COORD_W-1:0]         first_col;
        logic [COORD_W-1:0]         end_col;
        logic [COORD_W-1:0]         first_row;
        logic [COORD_W-1:0]         end_row;
        logic [TEX_W-1:0]           tex;
    } spp_result_t;

endpackage

// ----- src/sprite_screen_projection_core.sv -----
// Sprite screen projection core. Throughput one item per cycle unless the output stalls;
// every stage, including the five restoring dividers (one quotient bit per stage), is
// fully pipelined and advances on a common enable.
// A stalled output holds the whole pipeline; input is taken whenever the output slot is free.
// Reset (synchronous, aresetn low) clears all valid bits and loads the register defaults.
module sprite_screen_projection_core #(
    parameter int SPRITE_TEX_WIDTH = 64,
    parameter int GOAL_TEX_WIDTH   = 64,
    parameter int FRACTION_BITS    = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // sprite_x[23:0], sprite_y[47:24]
    input  logic [0:0]   s_tuser,   // sprite_kind[0]
    // Result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // depth[24:0], centre_column[38:25], sprite_size[51:39],
                                    // first_column[63:52], end_column[75:64],
                                    // first_row[87:76], end_row[99:88],
                                    // first_tex_column[107:100], zero[111:108]
    output logic [0:0]   m_tuser,   // behind_camera[0]
    // Register writes
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_wdata
);

    // Configuration registers
    logic [23:0]        camera_x_reg, camera_y_reg;
    logic signed [15:0] view_dir_x_reg, view_dir_y_reg;
    logic signed [15:0] cam_plane_x_reg, cam_plane_y_reg;
    logic [12:0]        screen_width_reg, screen_height_reg;
    logic [12:0]        dim_wr;
    spp_pkg::spp_cfg_t  cfg;

    // Pipeline hand-offs
    logic                 ce;
    logic                 xf_valid, proj_valid, res_valid;
    spp_pkg::spp_xf_t     xf;
    spp_pkg::spp_proj_t   proj;
    spp_pkg::spp_result_t res;

    // Screen sizes: zero is taken as one, anything above 4096 as 4096
    always_comb begin
        if (cfg_wdata[12:0] == '0) begin
            dim_wr = 13'd1;
        end else if (cfg_wdata[12:0] > spp_pkg::DIM_MAX) begin
            dim_wr = spp_pkg::DIM_MAX;
        end else begin
            dim_wr = cfg_wdata[12:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_x_reg      <= '0;
            camera_y_reg      <= '0;
            view_dir_x_reg    <= 16'sd16384;
            view_dir_y_reg    <= '0;
            cam_plane_x_reg   <= '0;
            cam_plane_y_reg   <= 16'sd10813;
            screen_width_reg  <= 13'd640;
            screen_height_reg <= 13'd480;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                spp_pkg::CFG_CAMERA_X:      camera_x_reg      <= cfg_wdata;
                spp_pkg::CFG_CAMERA_Y:      camera_y_reg      <= cfg_wdata;
                spp_pkg::CFG_VIEW_DIR_X:    view_dir_x_reg    <= $signed(cfg_wdata[15:0]);
                spp_pkg::CFG_VIEW_DIR_Y:    view_dir_y_reg    <= $signed(cfg_wdata[15:0]);
                spp_pkg::CFG_CAM_PLANE_X:   cam_plane_x_reg   <= $signed(cfg_wdata[15:0]);
                spp_pkg::CFG_CAM_PLANE_Y:   cam_plane_y_reg   <= $signed(cfg_wdata[15:0]);
                spp_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= dim_wr;
                spp_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= dim_wr;
            endcase
        end
    end

    assign cfg = '{cam_x: camera_x_reg, cam_y: camera_y_reg,
                   dir_x: view_dir_x_reg, dir_y: view_dir_y_reg,
                   plane_x: cam_plane_x_reg, plane_y: cam_plane_y_reg,
                   width: screen_width_reg, height: screen_height_reg};

    // Advance the whole pipeline unless a finished item is waiting at the output
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // Camera transform and tx/depth division
    spp_transform u_transform (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(s_tvalid),
        .sprite_x(s_tdata[23:0]),
        .sprite_y(s_tdata[47:24]),
        .sprite_kind(s_tuser[0]),
        .cfg(cfg),
        .out_valid(xf_valid),
        .out_xf(xf)
    );

    // Centre column and size
    spp_project #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_project (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(xf_valid),
        .in_xf(xf),
        .cfg(cfg),
        .out_valid(proj_valid),
        .out_proj(proj)
    );

    // Clipping and texture column; ends in the output register
    spp_clip #(
        .SPRITE_TEX_WIDTH(SPRITE_TEX_WIDTH),
        .GOAL_TEX_WIDTH(GOAL_TEX_WIDTH)
    ) u_clip (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(proj_valid),
        .in_proj(proj),
        .cfg(cfg),
        .out_valid(res_valid),
        .out_res(res)
    );

    assign m_tvalid = res_valid;
    assign m_tuser  = res.behind;
    assign m_tdata  = {4'b0000, res.tex, res.end_row, res.first_row, res.end_col,
                       res.first_col, res.size, res.centre, res.depth};

endmodule

// ----- src/spp_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage, with overflow flag.
// Depends on nothing; a sideband word travels alongside each item.
module spp_div #(
    parameter int NW = 24,
    parameter int DW = 13,
    parameter int QW = 9,
    parameter int SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          ce,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [SW-1:0] side_out
);

    localparam int HW = NW - QW;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [CW-1:0] hi_ext;
    logic [CW-1:0] den_ext;

    logic          v_reg    [0:QW];
    logic [DW-1:0] rem_reg  [0:QW];
    logic [QW-1:0] lq_reg   [0:QW];
    logic [DW-1:0] den_reg  [0:QW];
    logic          ovf_reg  [0:QW];
    logic [SW-1:0] side_reg [0:QW];

    logic [DW-1:0] rem_next [0:QW-1];
    logic [QW-1:0] lq_next  [0:QW-1];

    assign hi_ext  = CW'(num[NW-1:QW]);
    assign den_ext = CW'(den);

    // One trial subtraction per stage
    always_comb begin
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        logic [QW:0] sh;
        for (int k = 0; k < QW; k++) begin
            trial = {rem_reg[k], lq_reg[k][QW-1]};
            diff  = trial - {1'b0, den_reg[k]};
            ge    = (trial >= {1'b0, den_reg[k]});
            rem_next[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
            sh          = {lq_reg[k], ge};
            lq_next[k]  = sh[QW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QW; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (ce) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < QW; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= hi_ext[DW-1:0];
            lq_reg[0]   <= num[QW-1:0];
            den_reg[0]  <= den;
            ovf_reg[0]  <= (hi_ext >= den_ext);
            side_reg[0] <= side_in;
            for (int k = 0; k < QW; k++) begin
                rem_reg[k+1]  <= rem_next[k];
                lq_reg[k+1]   <= lq_next[k];
                den_reg[k+1]  <= den_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quo       = lq_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

// ----- src/spp_transform.sv -----
// Camera-space transform: offset, inverse camera matrix, and the tx/ty division.
// Depends on spp_pkg and spp_div.
module spp_transform (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  in_valid,
    input  logic [23:0]           sprite_x,
    input  logic [23:0]           sprite_y,
    input  logic                  sprite_kind,
    input  spp_pkg::spp_cfg_t     cfg,
    output logic                  out_valid,
    output spp_pkg::spp_xf_t      out_xf
);

    typedef struct packed {
        logic tx_neg;
        logic det_zero;
        logic kind;
    } tx_side_t;

    // Stage 1: offsets
    logic                                  v1_reg;
    logic signed [spp_pkg::DELTA_W-1:0]    dx_reg, dy_reg;
    logic                                  kind1_reg;
    // Stage 2: products
    logic                                  v2_reg;
    logic signed [spp_pkg::PROD_W-1:0]     ydx_reg, xdy_reg, pxdy_reg, pydx_reg;
    logic signed [31:0]                    det_a_reg, det_b_reg;
    logic                                  kind2_reg;
    // Stage 3: differences
    logic                                  v3_reg;
    logic signed [spp_pkg::NUM_W-1:0]      nx_reg, ny_reg;
    logic signed [spp_pkg::DET_W-1:0]      det_reg;
    logic                                  kind3_reg;
    // Stage 4: magnitudes
    logic                                  v4_reg;
    logic [spp_pkg::NUM_MAG_W-1:0]         nx_mag_reg, ny_mag_reg;
    logic [spp_pkg::DET_MAG_W-1:0]         det_mag_reg;
    logic                                  nx_neg_reg, ny_neg_reg, det_neg_reg, det_zero_reg;
    logic                                  kind4_reg;

    logic signed [spp_pkg::NUM_W-1:0]      nx_abs, ny_abs;
    logic signed [spp_pkg::DET_W-1:0]      det_abs;

    tx_side_t                              tx_side_in, tx_side_out;
    logic                                  ty_side_out;
    logic                                  dv_tx, dv_ty;
    logic [spp_pkg::TQ_W-1:0]              q_tx, q_ty;
    logic                                  ovf_tx, ovf_ty;

    logic [spp_pkg::TQ_W-1:0]              tx_mag, ty_mag, ty_lim;
    logic signed [spp_pkg::TX_W-1:0]       tx_m;
    logic signed [spp_pkg::DEPTH_W:0]      ty_m;
    spp_pkg::spp_xf_t                      xf_next;
    spp_pkg::spp_xf_t                      xf_reg;
    logic                                  v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= dv_tx;
        end
    end

    assign nx_abs  = nx_reg[spp_pkg::NUM_W-1] ? -nx_reg : nx_reg;
    assign ny_abs  = ny_reg[spp_pkg::NUM_W-1] ? -ny_reg : ny_reg;
    assign det_abs = det_reg[spp_pkg::DET_W-1] ? -det_reg : det_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            dx_reg    <= $signed({1'b0, sprite_x}) - $signed({1'b0, cfg.cam_x});
            dy_reg    <= $signed({1'b0, sprite_y}) - $signed({1'b0, cfg.cam_y});
            kind1_reg <= sprite_kind;

            ydx_reg   <= cfg.dir_y * dx_reg;
            xdy_reg   <= cfg.dir_x * dy_reg;
            pxdy_reg  <= cfg.plane_x * dy_reg;
            pydx_reg  <= cfg.plane_y * dx_reg;
            det_a_reg <= cfg.plane_x * cfg.dir_y;
            det_b_reg <= cfg.dir_x * cfg.plane_y;
            kind2_reg <= kind1_reg;

            nx_reg    <= spp_pkg::NUM_W'(ydx_reg) - spp_pkg::NUM_W'(xdy_reg);
            ny_reg    <= spp_pkg::NUM_W'(pxdy_reg) - spp_pkg::NUM_W'(pydx_reg);
            det_reg   <= spp_pkg::DET_W'(det_a_reg) - spp_pkg::DET_W'(det_b_reg);
            kind3_reg <= kind2_reg;

            nx_mag_reg   <= nx_abs[spp_pkg::NUM_MAG_W-1:0];
            ny_mag_reg   <= ny_abs[spp_pkg::NUM_MAG_W-1:0];
            det_mag_reg  <= det_abs[spp_pkg::DET_MAG_W-1:0];
            nx_neg_reg   <= nx_reg[spp_pkg::NUM_W-1];
            ny_neg_reg   <= ny_reg[spp_pkg::NUM_W-1];
            det_neg_reg  <= det_reg[spp_pkg::DET_W-1];
            det_zero_reg <= (det_reg == '0);
            kind4_reg    <= kind3_reg;

            xf_reg <= xf_next;
        end
    end

    assign tx_side_in = '{tx_neg: nx_neg_reg ^ det_neg_reg, det_zero: det_zero_reg,
                          kind: kind4_reg};

    spp_div #(
        .NW(spp_pkg::NUM_MAG_W + spp_pkg::VEC_SHIFT),
        .DW(spp_pkg::DET_MAG_W),
        .QW(spp_pkg::TQ_W),
        .SW($bits(tx_side_t))
    ) u_div_tx (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(v4_reg),
        .num({nx_mag_reg, {spp_pkg::VEC_SHIFT{1'b0}}}),
        .den(det_mag_reg),
        .side_in(tx_side_in),
        .out_valid(dv_tx),
        .quo(q_tx),
        .ovf(ovf_tx),
        .side_out(tx_side_out)
    );

    spp_div #(
        .NW(spp_pkg::NUM_MAG_W + spp_pkg::VEC_SHIFT),
        .DW(spp_pkg::DET_MAG_W),
        .QW(spp_pkg::TQ_W),
        .SW(1)
    ) u_div_ty (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(v4_reg),
        .num({ny_mag_reg, {spp_pkg::VEC_SHIFT{1'b0}}}),
        .den(det_mag_reg),
        .side_in(ny_neg_reg ^ det_neg_reg),
        .out_valid(dv_ty),
        .quo(q_ty),
        .ovf(ovf_ty),
        .side_out(ty_side_out)
    );

    // Saturate, restore signs, zero on a singular matrix
    always_comb begin
        tx_mag = (ovf_tx || q_tx > spp_pkg::TX_LIMIT) ? spp_pkg::TX_LIMIT : q_tx;
        ty_lim = ty_side_out ? spp_pkg::DEPTH_NEG_MAG : spp_pkg::DEPTH_POS_MAG;
        ty_mag = (ovf_ty || q_ty > ty_lim) ? ty_lim : q_ty;
        tx_m   = $signed({1'b0, tx_mag});
        ty_m   = $signed({1'b0, ty_mag[spp_pkg::DEPTH_W-1:0]});
        xf_next.kind = tx_side_out.kind;
        if (tx_side_out.det_zero) begin
            xf_next.tx = '0;
            xf_next.ty = '0;
        end else begin
            xf_next.tx = tx_side_out.tx_neg ? -tx_m : tx_m;
            xf_next.ty = spp_pkg::DEPTH_W'(ty_side_out ? -ty_m : ty_m);
        end
    end

    assign out_valid = v5_reg;
    assign out_xf    = xf_reg;

endmodule

// ----- src/spp_project.sv -----
// Perspective projection: centre column and square size from tx and depth.
// Depends on spp_pkg and spp_div.
module spp_project #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  in_valid,
    input  spp_pkg::spp_xf_t      in_xf,
    input  spp_pkg::spp_cfg_t     cfg,
    output logic                  out_valid,
    output spp_pkg::spp_proj_t    out_proj
);

    localparam int HALF_W  = spp_pkg::DIM_W - 1;
    localparam int CPROD_W = spp_pkg::SUM_MAG_W + HALF_W;
    localparam int SNUM_W  = spp_pkg::DIM_W + FRACTION_BITS;

    typedef struct packed {
        logic signed [spp_pkg::DEPTH_W-1:0] ty;
        logic                               ty_zero;
        logic                               tx_pos;
        logic                               tx_neg;
        logic                               c_neg;
        logic                               kind;
    } c_side_t;

    logic                                v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [spp_pkg::SUM_W-1:0]    sum_reg;
    logic signed [spp_pkg::DEPTH_W-1:0]  ty1_reg, ty2_reg, ty3_reg;
    logic                                txp1_reg, txn1_reg, kind1_reg;
    logic [spp_pkg::SUM_MAG_W-1:0]       s_mag_reg;
    logic [spp_pkg::DEPTH_W-1:0]         ty_mag2_reg, ty_mag3_reg;
    logic                                c_neg2_reg, c_neg3_reg;
    logic                                tyz2_reg, tyz3_reg;
    logic                                txp2_reg, txn2_reg, txp3_reg, txn3_reg;
    logic                                kind2_reg, kind3_reg;
    logic [CPROD_W-1:0]                  cprod_reg;

    logic signed [spp_pkg::SUM_W-1:0]    sum_abs;
    logic signed [spp_pkg::DEPTH_W:0]    ty_w, ty_abs;
    logic [HALF_W-1:0]                   half;

    c_side_t                             c_side_in, c_side_out;
    logic                                dv_c, dv_s;
    logic [spp_pkg::CENTRE_W-1:0]        q_c, q_s;
    logic                                ovf_c, ovf_s;
    logic [SNUM_W-1:0]                   s_num;

    logic signed [spp_pkg::CENTRE_W:0]   c_m;
    spp_pkg::spp_proj_t                  proj_next, proj_reg;

    assign half    = cfg.width[spp_pkg::DIM_W-1:1];
    assign sum_abs = sum_reg[spp_pkg::SUM_W-1] ? -sum_reg : sum_reg;
    assign ty_w    = (spp_pkg::DEPTH_W + 1)'(ty1_reg);
    assign ty_abs  = ty_w[spp_pkg::DEPTH_W] ? -ty_w : ty_w;
    assign s_num   = {cfg.height, {FRACTION_BITS{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= dv_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sum_reg   <= spp_pkg::SUM_W'(in_xf.tx) + spp_pkg::SUM_W'(in_xf.ty);
            ty1_reg   <= in_xf.ty;
            txp1_reg  <= !in_xf.tx[spp_pkg::TX_W-1] && (in_xf.tx != '0);
            txn1_reg  <= in_xf.tx[spp_pkg::TX_W-1];
            kind1_reg <= in_xf.kind;

            s_mag_reg   <= sum_abs[spp_pkg::SUM_MAG_W-1:0];
            ty_mag2_reg <= ty_abs[spp_pkg::DEPTH_W-1:0];
            c_neg2_reg  <= sum_reg[spp_pkg::SUM_W-1] ^ ty1_reg[spp_pkg::DEPTH_W-1];
            tyz2_reg    <= (ty1_reg == '0);
            ty2_reg     <= ty1_reg;
            txp2_reg    <= txp1_reg;
            txn2_reg    <= txn1_reg;
            kind2_reg   <= kind1_reg;

            cprod_reg   <= s_mag_reg * half;
            ty_mag3_reg <= ty_mag2_reg;
            c_neg3_reg  <= c_neg2_reg;
            tyz3_reg    <= tyz2_reg;
            ty3_reg     <= ty2_reg;
            txp3_reg    <= txp2_reg;
            txn3_reg    <= txn2_reg;
            kind3_reg   <= kind2_reg;

            proj_reg <= proj_next;
        end
    end

    assign c_side_in = '{ty: ty3_reg, ty_zero: tyz3_reg, tx_pos: txp3_reg, tx_neg: txn3_reg,
                         c_neg: c_neg3_reg, kind: kind3_reg};

    spp_div #(
        .NW(CPROD_W),
        .DW(spp_pkg::DEPTH_W),
        .QW(spp_pkg::CENTRE_W),
        .SW($bits(c_side_t))
    ) u_div_centre (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(v3_reg),
        .num(cprod_reg),
        .den(ty_mag3_reg),
        .side_in(c_side_in),
        .out_valid(dv_c),
        .quo(q_c),
        .ovf(ovf_c),
        .side_out(c_side_out)
    );

    spp_div #(
        .NW(SNUM_W),
        .DW(spp_pkg::DEPTH_W),
        .QW(spp_pkg::CENTRE_W),
        .SW(1)
    ) u_div_size (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(v3_reg),
        .num(s_num),
        .den(ty_mag3_reg),
        .side_in(1'b0),
        .out_valid(dv_s),
        .quo(q_s),
        .ovf(ovf_s),
        .side_out()
    );

    // Saturate centre and size; zero depth takes the edge or middle column
    always_comb begin
        c_m = $signed({1'b0, q_c});
        proj_next.kind   = c_side_out.kind;
        proj_next.depth  = c_side_out.ty;
        proj_next.behind = c_side_out.ty[spp_pkg::DEPTH_W-1] || c_side_out.ty_zero;
        if (c_side_out.ty_zero) begin
            proj_next.size = spp_pkg::SIZE_MAX;
            if (c_side_out.tx_pos) begin
                proj_next.centre = $signed(spp_pkg::CENTRE_POS_MAG);
            end else if (c_side_out.tx_neg) begin
                proj_next.centre = $signed(spp_pkg::CENTRE_NEG_MAG);
            end else begin
                proj_next.centre = $signed({2'b00, half});
            end
        end else begin
            if (ovf_s || q_s > spp_pkg::CENTRE_W'(spp_pkg::SIZE_MAX)) begin
                proj_next.size = spp_pkg::SIZE_MAX;
            end else begin
                proj_next.size = q_s[spp_pkg::SIZE_W-1:0];
            end
            if (c_side_out.c_neg) begin
                if (ovf_c || q_c > spp_pkg::CENTRE_NEG_MAG) begin
                    proj_next.centre = $signed(spp_pkg::CENTRE_NEG_MAG);
                end else begin
                    proj_next.centre = spp_pkg::CENTRE_W'(-c_m);
                end
            end else begin
                if (ovf_c || q_c > spp_pkg::CENTRE_POS_MAG) begin
                    proj_next.centre = $signed(spp_pkg::CENTRE_POS_MAG);
                end else begin
                    proj_next.centre = $signed(q_c);
                end
            end
        end
    end

    // The size divider runs in lockstep with the centre divider
    logic unused_dv_s;
    assign unused_dv_s = dv_s;

    assign out_valid = v4_reg;
    assign out_proj  = proj_reg;

endmodule

// ----- src/spp_clip.sv -----
// Screen clipping of the draw rectangle and texture column of the first drawn column.
// Depends on spp_pkg and spp_div.
module spp_clip #(
    parameter int SPRITE_TEX_WIDTH = 64,
    parameter int GOAL_TEX_WIDTH   = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ce,
    input  logic                  in_valid,
    input  spp_pkg::spp_proj_t    in_proj,
    input  spp_pkg::spp_cfg_t     cfg,
    output logic                  out_valid,
    output spp_pkg::spp_result_t  out_res
);

    localparam logic [spp_pkg::TW_W-1:0] SPRITE_TW = spp_pkg::TW_W'(SPRITE_TEX_WIDTH);
    localparam logic [spp_pkg::TW_W-1:0] GOAL_TW   = spp_pkg::TW_W'(GOAL_TEX_WIDTH);
    localparam int LEFT_W = 15;
    localparam int OFF_W  = 16;
    localparam int TNUM_W = (OFF_W - 1) + spp_pkg::TW_W;

    typedef struct packed {
        spp_pkg::spp_result_t        res;
        logic [spp_pkg::TW_W-1:0]    tw;
        logic                        off_bad;
    } t_side_t;

    logic                                 v1_reg, v2_reg, v3_reg, v4_reg;
    spp_pkg::spp_result_t                 r1_reg, r2_reg, r3_reg;
    logic                                 kind1_reg;
    logic signed [LEFT_W-1:0]             left_reg;
    logic [OFF_W-2:0]                     off_mag_reg;
    logic                                 off_bad2_reg, off_bad3_reg;
    logic [spp_pkg::TW_W-1:0]             tw2_reg, tw3_reg;
    logic [TNUM_W-1:0]                    tprod_reg;

    logic [spp_pkg::COORD_W-1:0]          hs, half_h, wm1, hm1, fx, ex, fy, ey;
    logic [spp_pkg::DIM_W-1:0]            ey_w;
    logic signed [LEFT_W-1:0]             left, right, wm1_s;
    logic signed [OFF_W-1:0]              off;

    t_side_t                              t_side_in, t_side_out;
    logic                                 dv_t;
    logic [spp_pkg::TW_W-1:0]             q_t, twm1;
    logic                                 ovf_t;
    spp_pkg::spp_result_t                 res_next, res_reg;

    always_comb begin
        hs     = in_proj.size[spp_pkg::SIZE_W-1:1];
        half_h = cfg.height[spp_pkg::DIM_W-1:1];
        wm1    = spp_pkg::COORD_W'(cfg.width - 1'b1);
        hm1    = spp_pkg::COORD_W'(cfg.height - 1'b1);
        wm1_s  = $signed({3'b000, wm1});
        left   = LEFT_W'(in_proj.centre) - $signed({3'b000, hs});
        right  = LEFT_W'(in_proj.centre) + $signed({3'b000, hs});
        if (left < 0) begin
            fx = '0;
        end else if (left > wm1_s) begin
            fx = wm1;
        end else begin
            fx = left[spp_pkg::COORD_W-1:0];
        end
        if (right < 0) begin
            ex = '0;
        end else if (right > wm1_s) begin
            ex = wm1;
        end else begin
            ex = right[spp_pkg::COORD_W-1:0];
        end
        fy   = (half_h >= hs) ? half_h - hs : '0;
        ey_w = {1'b0, half_h} + {1'b0, hs};
        ey   = (ey_w >= cfg.height) ? hm1 : ey_w[spp_pkg::COORD_W-1:0];
    end

    assign off = $signed({4'b0000, r1_reg.first_col}) - OFF_W'(left_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= dv_t;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            r1_reg.behind    <= in_proj.behind;
            r1_reg.depth     <= in_proj.depth;
            r1_reg.centre    <= in_proj.centre;
            r1_reg.size      <= in_proj.size;
            r1_reg.first_col <= fx;
            r1_reg.end_col   <= ex;
            r1_reg.first_row <= fy;
            r1_reg.end_row   <= ey;
            r1_reg.tex       <= '0;
            kind1_reg        <= in_proj.kind;
            left_reg         <= left;

            r2_reg       <= r1_reg;
            off_mag_reg  <= off[OFF_W-2:0];
            off_bad2_reg <= off[OFF_W-1] || (r1_reg.size == '0);
            tw2_reg      <= kind1_reg ? GOAL_TW : SPRITE_TW;

            r3_reg       <= r2_reg;
            tprod_reg    <= off_mag_reg * tw2_reg;
            off_bad3_reg <= off_bad2_reg;
            tw3_reg      <= tw2_reg;

            res_reg <= res_next;
        end
    end

    assign t_side_in = '{res: r3_reg, tw: tw3_reg, off_bad: off_bad3_reg};

    spp_div #(
        .NW(TNUM_W),
        .DW(spp_pkg::SIZE_W),
        .QW(spp_pkg::TW_W),
        .SW($bits(t_side_t))
    ) u_div_tex (
        .aclk(aclk), .aresetn(aresetn), .ce(ce),
        .in_valid(v3_reg),
        .num(tprod_reg),
        .den(r3_reg.size),
        .side_in(t_side_in),
        .out_valid(dv_t),
        .quo(q_t),
        .ovf(ovf_t),
        .side_out(t_side_out)
    );

    // Limit the texture column to the texture width; drop it when undefined
    always_comb begin
        twm1     = t_side_out.tw - 1'b1;
        res_next = t_side_out.res;
        if (t_side_out.off_bad) begin
            res_next.tex = '0;
        end else if (ovf_t || q_t > twm1) begin
            res_next.tex = twm1[spp_pkg::TEX_W-1:0];
        end else begin
            res_next.tex = q_t[spp_pkg::TEX_W-1:0];
        end
    end

    assign out_valid = v4_reg;
    assign out_res   = res_reg;

endmodule

// ----- verif/spp_checker.sv -----
// Checker for the sprite screen projection core: predicts each result from accepted items
// and compares it field by field. Depends on spp_pkg and on the register writes it watches.
module spp_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [47:0]  s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,
    input  logic [0:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_wdata,
    output int           fail_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint TEX_PLAIN = 64;
    localparam longint TEX_GOAL  = 64;

    longint cam_x, cam_y, dir_x, dir_y, plane_x, plane_y, scr_w, scr_h;
    spp_pkg::spp_result_t projections[$];

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic spp_pkg::spp_result_t project_sprite(logic [47:0] pos, logic kind);
        longint dx, dy, tw, det, nx, ny, tx, ty, half, centre, size, hs;
        longint fy, ey, left, fx, ex, tex, off;
        spp_pkg::spp_result_t r;
        dx = longint'(pos[23:0]) - cam_x;
        dy = longint'(pos[47:24]) - cam_y;
        tw = kind ? TEX_GOAL : TEX_PLAIN;
        det = plane_x * dir_y - dir_x * plane_y;
        nx = dir_y * dx - dir_x * dy;
        ny = plane_x * dy - plane_y * dx;
        tx = 0;
        ty = 0;
        half = scr_w / 2;
        if (det != 0) begin
            tx = (nx * 16384) / det;
            ty = (ny * 16384) / det;
        end
        ty = clip(ty, -16777216, 16777215);
        tx = clip(tx, -64'sd1099511627776, 64'sd1099511627776);
        if (ty == 0) begin
            centre = tx > 0 ? 8191 : (tx < 0 ? -8192 : half);
            size = 8191;
        end else begin
            centre = clip(((tx + ty) * half) / ty, -8192, 8191);
            size = (scr_h * 65536) / ty;
            if (size < 0) size = -size;
            if (size > 8191) size = 8191;
        end
        hs = size / 2;
        fy = scr_h / 2 - hs;
        if (fy < 0) fy = 0;
        ey = scr_h / 2 + hs;
        if (ey >= scr_h) ey = scr_h - 1;
        left = centre - hs;
        fx = clip(left, 0, scr_w - 1);
        ex = clip(centre + hs, 0, scr_w - 1);
        off = fx - left;
        if (size == 0 || off < 0) begin
            tex = 0;
        end else begin
            tex = (off * tw) / size;
            if (tex > tw - 1) tex = tw - 1;
        end
        r.behind = ty <= 0;
        r.depth = ty[spp_pkg::DEPTH_W-1:0];
        r.centre = centre[spp_pkg::CENTRE_W-1:0];
        r.size = size[spp_pkg::SIZE_W-1:0];
        r.first_col = fx[spp_pkg::COORD_W-1:0];
        r.end_col = ex[spp_pkg::COORD_W-1:0];
        r.first_row = fy[spp_pkg::COORD_W-1:0];
        r.end_row = ey[spp_pkg::COORD_W-1:0];
        r.tex = tex[spp_pkg::TEX_W-1:0];
        return r;
    endfunction

    function automatic longint screen_dim(logic [23:0] v);
        return clip(longint'(v[12:0]), 1, 4096);
    endfunction

    function automatic longint vec16(logic [23:0] v);
        return longint'($signed(v[15:0]));
    endfunction

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            fail_count++;
            $display("%0t %s: expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge aclk) begin
        spp_pkg::spp_result_t e;
        if (!aresetn) begin
            cam_x <= 0; cam_y <= 0; dir_x <= 16384; dir_y <= 0;
            plane_x <= 0; plane_y <= 10813; scr_w <= 640; scr_h <= 480;
            fail_count = 0;
            projections.delete();
            pending = 0;
        end else begin
            // settle the incoming item with the registers in force before this edge
            if (s_tvalid && s_tready)
                projections.push_back(project_sprite(s_tdata, s_tuser[0]));
            if (m_tvalid && m_tready) begin
                if (projections.size() == 0) begin
                    fail_count++;
                    $display("%0t unexpected item: expected none actual %h/%h",
                             $time, m_tdata, m_tuser);
                end else begin
                    e = projections.pop_front();
                    compare_field("behind_camera", e.behind, m_tuser[0]);
                    compare_field("depth", longint'($unsigned(e.depth)), m_tdata[24:0]);
                    compare_field("centre_column", longint'($unsigned(e.centre)),
                                  m_tdata[38:25]);
                    compare_field("sprite_size", e.size, m_tdata[51:39]);
                    compare_field("first_column", e.first_col, m_tdata[63:52]);
                    compare_field("end_column", e.end_col, m_tdata[75:64]);
                    compare_field("first_row", e.first_row, m_tdata[87:76]);
                    compare_field("end_row", e.end_row, m_tdata[99:88]);
                    compare_field("first_tex_column", e.tex, m_tdata[107:100]);
                end
            end
            pending = projections.size();
            if (cfg_wr_en) begin
                case (cfg_index)
                    spp_pkg::CFG_CAMERA_X:      cam_x <= longint'(cfg_wdata);
                    spp_pkg::CFG_CAMERA_Y:      cam_y <= longint'(cfg_wdata);
                    spp_pkg::CFG_VIEW_DIR_X:    dir_x <= vec16(cfg_wdata);
                    spp_pkg::CFG_VIEW_DIR_Y:    dir_y <= vec16(cfg_wdata);
                    spp_pkg::CFG_CAM_PLANE_X:   plane_x <= vec16(cfg_wdata);
                    spp_pkg::CFG_CAM_PLANE_Y:   plane_y <= vec16(cfg_wdata);
                    spp_pkg::CFG_SCREEN_WIDTH:  scr_w <= screen_dim(cfg_wdata);
                    spp_pkg::CFG_SCREEN_HEIGHT: scr_h <= screen_dim(cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the sprite screen projection testbench: clock, reset, register phases and item stimulus.
// Depends on spp_pkg, the core under test and spp_checker, which does all prediction.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 80;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;   // sprite_x[23:0], sprite_y[47:24]
    logic [0:0]   s_tuser = '0;   // sprite_kind[0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;        // depth, centre, size, columns, rows, texture column
    logic [0:0]   m_tuser;        // behind_camera[0]
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [23:0]  cfg_wdata = '0;
    int           fail_count;
    int           pending;
    bit           hold_off = 1'b0;   // long receiver stall requested by the stimulus
    bit           random_stall = 1'b1;

    always #1 aclk = ~aclk;

    sprite_screen_projection_core dut (.*);

    spp_checker checker_i (.*);

    // Receiver: random stall per item, plus a long hold-off on request.
    initial begin : sink
        int gap;
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            gap = random_stall ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin : watchdog
        #2ms;
        $display("sprite_screen_projection_core: mismatch");
        $finish;
    end

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one sprite; keep tvalid high if the next item follows without a gap.
    task automatic send_sprite(logic [23:0] sx, logic [23:0] sy, logic kind, int gap);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {sy, sx};
        s_tuser <= kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    // Sprite near the camera, mostly in the drawable range; sometimes any position.
    task automatic random_sprite(logic [23:0] cx, logic [23:0] cy, int gmax);
        logic [23:0] sx, sy;
        if ($urandom_range(0, 4) == 0) begin
            sx = 24'($urandom);
            sy = 24'($urandom);
        end else begin
            sx = cx + 24'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
            sy = cy + 24'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
        end
        send_sprite(sx, sy, 1'($urandom_range(0, 1)), $urandom_range(0, gmax));
    endtask

    initial begin : stimulus
        logic [23:0] cx, cy;
        int n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset registers, field extremes, both kinds, sprite on the camera.
        send_sprite(24'h0, 24'h0, 1'b0, 0);
        send_sprite(24'hFFFFFF, 24'hFFFFFF, 1'b1, 0);
        send_sprite(24'h020000, 24'h0, 1'b0, 0);
        send_sprite(24'h020000, 24'h008000, 1'b1, 1);
        send_sprite(24'h000100, 24'hFFFFFF, 1'b0, 0);
        send_sprite(24'h0A0000, 24'h000001, 1'b1, 0);
        send_sprite(24'h000001, 24'h000000, 1'b0, 2);
        drain();

        // Singular matrix: every sprite gives zero depth.
        write_reg(spp_pkg::CFG_VIEW_DIR_X, 24'h0);
        write_reg(spp_pkg::CFG_CAM_PLANE_Y, 24'h0);
        send_sprite(24'h100000, 24'h100000, 1'b0, 0);
        send_sprite(24'hFFFFFF, 24'h0, 1'b1, 0);
        drain();

        // Extreme vectors and screen sizes, including zero and out-of-range dimensions.
        write_reg(spp_pkg::CFG_CAMERA_X, 24'hFFFFFF);
        write_reg(spp_pkg::CFG_CAMERA_Y, 24'hFFFFFF);
        write_reg(spp_pkg::CFG_VIEW_DIR_X, 24'h008000);
        write_reg(spp_pkg::CFG_VIEW_DIR_Y, 24'h007FFF);
        write_reg(spp_pkg::CFG_CAM_PLANE_X, 24'h7FFF);
        write_reg(spp_pkg::CFG_CAM_PLANE_Y, 24'hFF8000);
        write_reg(spp_pkg::CFG_SCREEN_WIDTH, 24'h0);
        write_reg(spp_pkg::CFG_SCREEN_HEIGHT, 24'h1FFF);
        send_sprite(24'h0, 24'h0, 1'b0, 0);
        send_sprite(24'hFFFFFF, 24'hFFFFFE, 1'b1, 0);
        send_sprite(24'h7FFFFF, 24'h800000, 1'b0, 0);
        send_sprite(24'hFFFF00, 24'h000000, 1'b1, 0);
        drain();
        write_reg(spp_pkg::CFG_SCREEN_WIDTH, 24'd4096);
        write_reg(spp_pkg::CFG_SCREEN_HEIGHT, 24'd1);
        send_sprite(24'hFFFF00, 24'hFF0000, 1'b0, 0);
        send_sprite(24'h000000, 24'hFFFFFF, 1'b1, 0);
        send_sprite(24'h123456, 24'hABCDEF, 1'b0, 0);
        drain();

        // Random phases: new camera each phase, then sprites around it.
        for (int phase = 0; phase < 19; phase++) begin
            cx = 24'($urandom);
            cy = 24'($urandom);
            write_reg(spp_pkg::CFG_CAMERA_X, cx);
            write_reg(spp_pkg::CFG_CAMERA_Y, cy);
            write_reg(spp_pkg::CFG_VIEW_DIR_X, 24'($urandom));
            write_reg(spp_pkg::CFG_VIEW_DIR_Y, 24'($urandom));
            write_reg(spp_pkg::CFG_CAM_PLANE_X, 24'($urandom));
            write_reg(spp_pkg::CFG_CAM_PLANE_Y, 24'($urandom));
            write_reg(spp_pkg::CFG_SCREEN_WIDTH,
                      24'(phase % 4 == 0 ? $urandom : $urandom_range(1, 1024)));
            write_reg(spp_pkg::CFG_SCREEN_HEIGHT,
                      24'(phase % 4 == 1 ? $urandom : $urandom_range(1, 1024)));
            if (phase == 3) write_reg(3'($urandom_range(0, 7)), 24'($urandom));
            random_stall = (phase % 5 != 2);
            // long receiver stall with the sender still offering items
            if (phase == 6) hold_off = 1'b1;
            n = 100;
            for (int i = 0; i < n; i++)
                random_sprite(cx, cy, (phase % 5 == 2) ? 0 : 8);
            // sender pause until every result is back
            drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("sprite_screen_projection_core: match");
        end else begin
            $display("sprite_screen_projection_core: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/spp_pkg.sv
src/spp_div.sv
src/spp_transform.sv
src/spp_project.sv
src/spp_clip.sv
src/sprite_screen_projection_core.sv
verif/spp_checker.sv
verif/testbench.sv
